// ===== hw/rtl/tch_pkg.sv =====
package tch_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int ANG_W             = 34;
  localparam int TRIG_W            = 27;
  localparam int ANGLE_W           = 16;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [TRIG_W-1:0] GAIN_Q24   = 27'sd10188014;
  localparam logic signed [ANGLE_W-1:0] HEAD_MAX  = 16'sd25736;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] v;
    v = '0;
    unique case (idx)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tch_sincos.sv =====
// Pipelined rotation-mode CORDIC: one stage per iteration, valid travels along.
module tch_sincos #(
  parameter int STAGES = tch_pkg::CORDIC_STAGES_DEF,
  parameter int TAG_W  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic signed [tch_pkg::ANGLE_W-1:0] ang,
  input  logic [TAG_W-1:0]                  tag_in,
  output logic                              out_vld,
  output logic signed [tch_pkg::TRIG_W-1:0] sin_o,
  output logic signed [tch_pkg::TRIG_W-1:0] cos_o,
  output logic [TAG_W-1:0]                  tag_out
);
  localparam int N = (STAGES < tch_pkg::ATAN_ENTRIES) ? STAGES : tch_pkg::ATAN_ENTRIES;
  localparam int W = tch_pkg::TRIG_W;
  localparam int AW = tch_pkg::ANG_W;

  logic                 v_r   [N+1];
  logic signed [W-1:0]  x_r   [N+1];
  logic signed [W-1:0]  y_r   [N+1];
  logic signed [AW-1:0] z_r   [N+1];
  logic                 neg_r [N+1];
  logic [TAG_W-1:0]     tag_r [N+1];

  logic signed [AW-1:0] z0;
  logic signed [AW-1:0] z0_nxt;
  logic                 neg_nxt;

  // Fold the angle into -pi/2..pi/2.
  always_comb begin
    z0 = AW'(ang) <<< 17;
    z0_nxt = z0;
    neg_nxt = 1'b0;
    if (z0 > tch_pkg::ANG_HALF_PI) begin
      z0_nxt = z0 - tch_pkg::ANG_PI;
      neg_nxt = 1'b1;
    end else if (z0 < -tch_pkg::ANG_HALF_PI) begin
      z0_nxt = z0 + tch_pkg::ANG_PI;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv) v_r[0] <= in_vld;
    if (adv) begin
      x_r[0]   <= tch_pkg::GAIN_Q24;
      y_r[0]   <= '0;
      z_r[0]   <= z0_nxt;
      neg_r[0] <= neg_nxt;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (adv) v_r[i+1] <= v_r[i];
      if (adv) begin
        neg_r[i+1] <= neg_r[i];
        tag_r[i+1] <= tag_r[i];
        if (!z_r[i][AW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - tch_pkg::atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + tch_pkg::atan_entry(i);
        end
      end
    end
  end

  assign out_vld = v_r[N];
  assign sin_o   = neg_r[N] ? -y_r[N] : y_r[N];
  assign cos_o   = neg_r[N] ? -x_r[N] : x_r[N];
  assign tag_out = tag_r[N];
endmodule

// ===== hw/rtl/tch_rotate.sv =====
// Rotation into the level frame: coefficient products, then sample products, then sums.
module tch_rotate #(
  parameter int SW = tch_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic signed [tch_pkg::TRIG_W-1:0] sr,
  input  logic signed [tch_pkg::TRIG_W-1:0] cr,
  input  logic signed [tch_pkg::TRIG_W-1:0] sp,
  input  logic signed [tch_pkg::TRIG_W-1:0] cp,
  input  logic signed [SW-1:0]              bx_raw,
  input  logic signed [SW-1:0]              by_neg,
  input  logic signed [SW-1:0]              bz_raw,
  output logic                              out_vld,
  output logic signed [SW:0]                lx,
  output logic signed [SW:0]                ly,
  output logic signed [SW:0]                lz
);
  localparam int TW = tch_pkg::TRIG_W;
  localparam int PW = 2 * TW;
  localparam int BW = SW + 1;
  localparam int MW = BW + TW;
  localparam int SUMW = MW + 2;
  localparam logic signed [PW-1:0] RND_P = PW'(64'sd8388608);
  localparam logic signed [SUMW-1:0] RND_S = SUMW'(64'sd8388608);

  // stage A: coefficient products
  logic                 va_r;
  logic signed [TW-1:0] ka_r [4];
  logic signed [TW-1:0] sr_a_r, cr_a_r, sp_a_r, cp_a_r;
  logic signed [BW-1:0] bx_a_r, by_a_r, bz_a_r;
  logic signed [PW-1:0] p0, p1, p2, p3;

  assign p0 = (PW'(sp) * PW'(sr)) + RND_P;
  assign p1 = (PW'(sp) * PW'(cr)) + RND_P;
  assign p2 = (PW'(cp) * PW'(sr)) + RND_P;
  assign p3 = (PW'(cp) * PW'(cr)) + RND_P;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= in_vld;
    if (adv) begin
      ka_r[0] <= TW'(p0 >>> 24);
      ka_r[1] <= TW'(p1 >>> 24);
      ka_r[2] <= TW'(p2 >>> 24);
      ka_r[3] <= TW'(p3 >>> 24);
      sr_a_r <= sr; cr_a_r <= cr; sp_a_r <= sp; cp_a_r <= cp;
      bx_a_r <= BW'(bx_raw);
      by_a_r <= -BW'(by_neg);
      bz_a_r <= BW'(bz_raw);
    end
  end

  // stage B: sample times coefficient
  logic                 vb_r;
  logic signed [MW-1:0] m_r [8];

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
    if (adv) begin
      m_r[0] <= MW'(bx_a_r) * MW'(cp_a_r);
      m_r[1] <= MW'(by_a_r) * MW'(ka_r[0]);
      m_r[2] <= MW'(bz_a_r) * MW'(ka_r[1]);
      m_r[3] <= MW'(by_a_r) * MW'(cr_a_r);
      m_r[4] <= MW'(bz_a_r) * MW'(sr_a_r);
      m_r[5] <= MW'(bx_a_r) * MW'(sp_a_r);
      m_r[6] <= MW'(by_a_r) * MW'(ka_r[2]);
      m_r[7] <= MW'(bz_a_r) * MW'(ka_r[3]);
    end
  end

  // stage C: sums, rounding, clamp
  logic                   vc_r;
  logic signed [SW:0]     lx_r, ly_r, lz_r;
  logic signed [SUMW-1:0] sx, sy, sz, qx, qy, qz;

  function automatic logic signed [SW:0] sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi, lo;
    hi = SUMW'((64'sd1 <<< SW) - 64'sd1);
    lo = -SUMW'(64'sd1 <<< SW);
    if (v > hi) return hi[SW:0];
    if (v < lo) return lo[SW:0];
    return v[SW:0];
  endfunction

  always_comb begin
    sx = SUMW'(m_r[0]) + SUMW'(m_r[1]) + SUMW'(m_r[2]) + RND_S;
    sy = SUMW'(m_r[3]) - SUMW'(m_r[4]) + RND_S;
    sz = -SUMW'(m_r[5]) + SUMW'(m_r[6]) + SUMW'(m_r[7]) + RND_S;
    qx = sx >>> 24;
    qy = sy >>> 24;
    qz = sz >>> 24;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
    if (adv) begin
      lx_r <= sat(qx);
      ly_r <= sat(qy);
      lz_r <= sat(qz);
    end
  end

  assign out_vld = vc_r;
  assign lx = lx_r;
  assign ly = ly_r;
  assign lz = lz_r;
endmodule

// ===== hw/rtl/tch_atan2.sv =====
// Pipelined vectoring-mode CORDIC with the level components riding alongside.
module tch_atan2 #(
  parameter int SW     = tch_pkg::SAMPLE_WIDTH_DEF,
  parameter int STAGES = tch_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_vld,
  input  logic signed [SW:0]                 lx,
  input  logic signed [SW:0]                 ly,
  input  logic signed [SW:0]                 lz,
  output logic                               out_vld,
  output logic signed [SW:0]                 lx_o,
  output logic signed [SW:0]                 ly_o,
  output logic signed [SW:0]                 lz_o,
  output logic signed [tch_pkg::ANGLE_W-1:0] hd_o
);
  localparam int N  = (STAGES < tch_pkg::ATAN_ENTRIES) ? STAGES : tch_pkg::ATAN_ENTRIES;
  localparam int VW = SW + 1 + 12 + 2;
  localparam int AW = tch_pkg::ANG_W;
  localparam int LW = 3 * (SW + 1);

  logic                 v_r  [N+1];
  logic                 zero_r [N+1];
  logic signed [VW-1:0] x_r  [N+1];
  logic signed [VW-1:0] y_r  [N+1];
  logic signed [AW-1:0] z_r  [N+1];
  logic [LW-1:0]        l_r  [N+1];

  logic signed [VW-1:0] x0, y0;

  assign x0 = VW'(lx) <<< 12;
  assign y0 = VW'(ly) <<< 12;

  // Turn a left-half vector by pi.
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv) v_r[0] <= in_vld;
    if (adv) begin
      zero_r[0] <= (lx == '0) && (ly == '0);
      l_r[0]    <= {lx, ly, lz};
      if (x0[VW-1]) begin
        x_r[0] <= -x0;
        y_r[0] <= -y0;
        z_r[0] <= y0[VW-1] ? -tch_pkg::ANG_PI : tch_pkg::ANG_PI;
      end else begin
        x_r[0] <= x0;
        y_r[0] <= y0;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (adv) v_r[i+1] <= v_r[i];
      if (adv) begin
        zero_r[i+1] <= zero_r[i];
        l_r[i+1]    <= l_r[i];
        if (y_r[i][VW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - tch_pkg::atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + tch_pkg::atan_entry(i);
        end
      end
    end
  end

  // Round to Q3.13 and clamp to +-pi; a zero level vector gives zero heading.
  logic signed [AW-1:0] zr;
  logic signed [AW-1:0] hmax;
  always_comb begin
    hmax = AW'(tch_pkg::HEAD_MAX);
    zr = (z_r[N] + AW'(64'sd65536)) >>> 17;
    if (zero_r[N]) hd_o = '0;
    else if (zr > hmax) hd_o = tch_pkg::HEAD_MAX;
    else if (zr < -hmax) hd_o = -tch_pkg::HEAD_MAX;
    else hd_o = zr[tch_pkg::ANGLE_W-1:0];
  end

  assign out_vld = v_r[N];
  assign lx_o = l_r[N][LW-1 -: SW+1];
  assign ly_o = l_r[N][2*(SW+1)-1 -: SW+1];
  assign lz_o = l_r[N][SW:0];
endmodule

// ===== hw/rtl/tilt_compensated_heading_core.sv =====
// Pipeline: sin/cos CORDIC pipes, then rotation stages A, B and C, then the atan2 CORDIC,
//   then the output register.
// Throughput: one transaction per cycle; every stage is a register and the whole
//   pipeline advances together whenever the output register is free or being drained.
// Reset: synchronous active-low rst_n clears all valid bits; no data state is kept.
module tilt_compensated_heading_core #(
  parameter int SAMPLE_WIDTH  = tch_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = tch_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_mag_x_raw,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_mag_y_raw,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_mag_z_raw,
  input  logic signed [tch_pkg::ANGLE_W-1:0] in_roll_angle,
  input  logic signed [tch_pkg::ANGLE_W-1:0] in_pitch_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_WIDTH:0]       out_level_x,
  output logic signed [SAMPLE_WIDTH:0]       out_level_y,
  output logic signed [SAMPLE_WIDTH:0]       out_level_z,
  output logic signed [tch_pkg::ANGLE_W-1:0] out_heading
);
  localparam int TW = tch_pkg::TRIG_W;
  localparam int SAMP3 = 3 * SAMPLE_WIDTH;

  logic adv;
  logic out_valid_r;

  // Advance the pipeline when the output slot is empty or being taken.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // roll CORDIC carries the samples; pitch CORDIC runs in lockstep
  logic                    rv, pv;
  logic signed [TW-1:0]    sr, cr, sp, cp;
  logic [SAMP3-1:0]        samp;
  logic [0:0]              ptag;

  tch_sincos #(.STAGES(CORDIC_STAGES), .TAG_W(SAMP3)) u_roll (
    .clk, .rst_n, .adv,
    .in_vld (in_valid),
    .ang    (in_roll_angle),
    .tag_in ({in_mag_y_raw, in_mag_x_raw, in_mag_z_raw}),
    .out_vld(rv),
    .sin_o  (sr),
    .cos_o  (cr),
    .tag_out(samp)
  );

  tch_sincos #(.STAGES(CORDIC_STAGES), .TAG_W(1)) u_pitch (
    .clk, .rst_n, .adv,
    .in_vld (in_valid),
    .ang    (in_pitch_angle),
    .tag_in (1'b0),
    .out_vld(pv),
    .sin_o  (sp),
    .cos_o  (cp),
    .tag_out(ptag)
  );

  logic                      rot_v;
  logic signed [SAMPLE_WIDTH:0] lx, ly, lz;

  tch_rotate #(.SW(SAMPLE_WIDTH)) u_rot (
    .clk, .rst_n, .adv,
    .in_vld (rv && (ptag == 1'b0)),
    .sr, .cr, .sp, .cp,
    .bx_raw (samp[SAMP3-1 -: SAMPLE_WIDTH]),
    .by_neg (samp[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH]),
    .bz_raw (samp[SAMPLE_WIDTH-1:0]),
    .out_vld(rot_v),
    .lx, .ly, .lz
  );

  logic                         at_v;
  logic signed [SAMPLE_WIDTH:0] ax, ay, az;
  logic signed [tch_pkg::ANGLE_W-1:0] hd;

  tch_atan2 #(.SW(SAMPLE_WIDTH), .STAGES(CORDIC_STAGES)) u_atan (
    .clk, .rst_n, .adv,
    .in_vld (rot_v),
    .lx, .ly, .lz,
    .out_vld(at_v),
    .lx_o   (ax),
    .ly_o   (ay),
    .lz_o   (az),
    .hd_o   (hd)
  );

  // Output register: hold until the transaction completes.
  logic signed [SAMPLE_WIDTH:0]       lx_out_r, ly_out_r, lz_out_r;
  logic signed [tch_pkg::ANGLE_W-1:0] hd_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= at_v;
    if (adv) begin
      lx_out_r <= ax;
      ly_out_r <= ay;
      lz_out_r <= az;
      hd_out_r <= hd;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level_x = lx_out_r;
  assign out_level_y = ly_out_r;
  assign out_level_z = lz_out_r;
  assign out_heading = hd_out_r;

  // Both sine/cosine pipes stay aligned.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n) rv == pv)
    else $error("roll and pitch pipes out of step");

  // A stalled result is held (heading and level x are checked).
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading) && $stable(out_level_x))
    else $error("result changed while stalled");

  // Heading stays within +-pi.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading <= tch_pkg::HEAD_MAX) && (out_heading >= -tch_pkg::HEAD_MAX))
    else $error("heading out of range");

  // Zero level vector gives zero heading.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level_x == '0 && out_level_y == '0 |-> out_heading == '0)
    else $error("nonzero heading for zero vector");
endmodule
